// ===== rtl/ffd_pkg.sv =====
package ffd_pkg;

   localparam int INTERVAL_W = 24;
   localparam int RATIO_W    = 16;
   localparam int NIB_W      = 4;
   localparam int VEL_W      = 32;
   localparam int ACC_W      = 48;
   localparam int FT_W       = 28;
   localparam int CSR_IDX_W  = 3;

   // shared divider: numerator up to |dv|*1e6 + rounding, denominator up to clean*256
   localparam int NUM_W      = 53;
   localparam int DEN_W      = 32;
   localparam int MUL_A_W    = 40;
   localparam int MUL_B_W    = 20;
   localparam int MUL_W      = MUL_A_W + MUL_B_W;

   localparam logic [MUL_B_W-1:0] US_PER_S  = 20'd1000000;
   localparam logic [ACC_W-1:0]   ACC_INIT  = 48'd26;
   localparam logic [ACC_W-1:0]   ACC_MAX   = 48'h7FFF_FFFF_FFFF;

   localparam logic [INTERVAL_W-1:0] RST_MIN_INTERVAL = 24'd10000;
   localparam logic [INTERVAL_W-1:0] RST_MAX_INTERVAL = 24'd1000000;
   localparam logic [RATIO_W-1:0]    RST_DOWN_RATIO   = 16'd192;
   localparam logic [RATIO_W-1:0]    RST_UP_RATIO     = 16'd448;
   localparam logic [NIB_W-1:0]      RST_FLANK_LENGTH = 4'd3;
   localparam logic [NIB_W-1:0]      RST_WINDOW       = 4'd1;
   localparam logic [NIB_W-1:0]      RST_ERRORS       = 4'd0;
   localparam logic [INTERVAL_W-1:0] RST_ANGLE        = 24'd6588397;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_INTERVAL = 3'd0,
      CSR_MAX_INTERVAL = 3'd1,
      CSR_DOWN_RATIO   = 3'd2,
      CSR_UP_RATIO     = 3'd3,
      CSR_FLANK_LENGTH = 3'd4,
      CSR_WINDOW       = 3'd5,
      CSR_ERRORS       = 3'd6,
      CSR_ANGLE        = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_INIT_SUM,
      ST_INIT_VDIV,
      ST_INIT_VWAIT,
      ST_IDLE,
      ST_CHK_D1,
      ST_CHK_D2,
      ST_CHK_U1,
      ST_CHK_U2,
      ST_DECIDE,
      ST_CLEAN_DIV,
      ST_CLEAN_WAIT,
      ST_VEL_DIV,
      ST_VEL_WAIT,
      ST_ACC_MUL,
      ST_ACC_DIV,
      ST_ACC_WAIT,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

endpackage

// ===== rtl/ffd_div.sv =====
module ffd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  ffd_pkg::div_req_type          req,
   output logic                          done,
   output logic [ffd_pkg::NUM_W-1:0]     quo
);

   localparam int NUM_W = ffd_pkg::NUM_W;
   localparam int DEN_W = ffd_pkg::DEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]} - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DEN_W-2:0], quo_ff[NUM_W-1]};
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (req.start) begin
         den_ff <= req.den;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/flywheel_flank_detector_top.sv =====
// channel | ports         | beat contents
// --------+---------------+------------------------------------------------
// input   | req_t*        | tdata: interval_us
// result  | rsp_t*        | tdata: clean, velocity, accel, flank time, begin
//         |               | interval, begin accel; tuser: flags
// config  | csr_*         | write only, index per register list
//
// Each interval runs the plausibility products on the shared multiplier
// (CHK_D1 to CHK_U2), three passes of the one-bit-a-cycle divider (clean
// average, velocity, acceleration, each with a start and a finish state),
// one multiply, a flank walk from the flank length down to entry zero, the
// result write and a return to idle. A zero clean interval skips the last
// two divisions. Reset or any register write reloads all history;
// req_tready stays low until the reload is done, with its velocity division
// when the maximum interval is nonzero. A stalled result stays in the output
// register; the next beat is accepted meanwhile, and held back only at completion until the slot frees.
module flywheel_flank_detector_top #(
   parameter int FLANK_DEPTH = 16,
   parameter int MAX_WINDOW  = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,   // [23:0] interval_us
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [23:0] clean_interval, [55:24] velocity, [103:56] acceleration,
   // [131:104] flank_time, [155:132] begin_interval,
   // [203:156] begin_acceleration, [207:204] zero
   output logic [207:0]  rsp_tdata,
   // [0] powered, [1] unpowered, [2] out_of_bounds, [3] corrected
   output logic [3:0]    rsp_tuser,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [23:0]   csr_wdata
);

   localparam int IW      = ffd_pkg::INTERVAL_W;
   localparam int VW      = ffd_pkg::VEL_W;
   localparam int AW      = ffd_pkg::ACC_W;
   localparam int NUM_W   = ffd_pkg::NUM_W;
   localparam int DEN_W   = ffd_pkg::DEN_W;
   localparam int MUL_W   = ffd_pkg::MUL_W;
   localparam int MA_W    = ffd_pkg::MUL_A_W;
   localparam int MB_W    = ffd_pkg::MUL_B_W;
   localparam int IDX_W   = $clog2(FLANK_DEPTH);
   localparam int LAST    = FLANK_DEPTH - 1;
   localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
   localparam int WIX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W   = IW + WIN_W;
   localparam int LIM_MAX = ((MAX_WINDOW < 2) ? 2 : MAX_WINDOW) + 1;
   localparam int CNT_W   = $clog2(LIM_MAX + 1);
   localparam int FTA_W   = ffd_pkg::FT_W + 1;

   // configuration
   logic [IW-1:0]              min_ff, max_ff, angle_ff;
   logic [ffd_pkg::RATIO_W-1:0] down_ff, up_ff;
   logic [ffd_pkg::NIB_W-1:0]   flank_ff, window_ff, errors_ff;

   // history
   logic [IW-1:0] raw_ff   [FLANK_DEPTH];
   logic [IW-1:0] clean_ff [FLANK_DEPTH];
   logic [VW-1:0] vel_ff   [FLANK_DEPTH];
   logic [AW-1:0] acc_ff   [FLANK_DEPTH];
   logic [IW-1:0] win_ff   [MAX_WINDOW];
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] corr_cnt_ff;

   // working registers
   ffd_pkg::state_type state_ff, state_in;
   logic [MUL_W-1:0] mul_ff, lo_ff;
   logic [IW-1:0]    prev_ff, data_ff, cur_ff;
   logic             oob_ff, corr_ff, neg_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [FTA_W-1:0] ft_ff;
   logic [3:0]       perr_ff, uerr_ff;
   logic             rsp_valid_ff;
   logic [207:0]     rsp_data_ff;
   logic [3:0]       rsp_user_ff;

   // control
   logic             mul_en;
   logic [MA_W-1:0]  mul_a;
   logic [MB_W-1:0]  mul_b;
   ffd_pkg::div_req_type div_req;
   logic             div_done;
   logic [NUM_W-1:0] div_quo;

   // derived
   logic [WIN_W-1:0] n;
   logic [CNT_W-1:0] limit;
   logic [IDX_W-1:0] len, bi, ai;
   logic             accept, out_free;
   logic [IW-1:0]    x, data, prev;
   logic             oob;
   logic [VW-1:0]    v_sat, mag;
   logic [AW-1:0]    a_mag;
   logic [MUL_W-1:0] s256;
   logic             pass;
   logic [IW-1:0]    walk_a, walk_b;

   always_comb begin
      if (window_ff == '0) begin
         n = WIN_W'(1);
      end else if (32'(window_ff) > MAX_WINDOW) begin
         n = WIN_W'(MAX_WINDOW);
      end else begin
         n = WIN_W'(window_ff);
      end
      limit = (n < WIN_W'(2)) ? CNT_W'(2) : CNT_W'(n);
      if (32'(flank_ff) < LAST) begin
         len = IDX_W'(flank_ff);
      end else begin
         len = IDX_W'(LAST);
      end
      bi = len;
      if (flank_ff == '0) begin
         ai = '0;
      end else if (32'(flank_ff) - 1 > LAST) begin
         ai = IDX_W'(LAST);
      end else begin
         ai = IDX_W'(flank_ff - 1'b1);
      end
   end

   assign x        = req_tdata[IW-1:0];
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   // with no shift, entry 1 never moves and stays the previous value
   assign prev     = (len == '0) ? clean_ff[1] : clean_ff[0];
   assign oob      = (x < min_ff) || (x > max_ff);
   assign data     = oob ? prev : x;
   assign v_sat    = (div_quo[NUM_W-1:VW] != '0) ? '1 : div_quo[VW-1:0];
   assign a_mag    = (div_quo[NUM_W-1:AW-1] != '0) ? ffd_pkg::ACC_MAX : div_quo[AW-1:0];
   assign mag      = (vel_ff[0] < vel_ff[1]) ? vel_ff[1] - vel_ff[0] : vel_ff[0] - vel_ff[1];
   assign s256     = MUL_W'({sum_ff, 8'd0});
   assign pass     = (s256 > lo_ff) && (s256 < mul_ff);
   assign walk_a   = clean_ff[idx_ff];
   assign walk_b   = clean_ff[idx_ff - 1'b1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffd_pkg::ST_INIT:       state_in = ffd_pkg::ST_INIT_SUM;
         ffd_pkg::ST_INIT_SUM:   state_in = ffd_pkg::ST_INIT_VDIV;
         ffd_pkg::ST_INIT_VDIV:  state_in = (max_ff == '0) ? ffd_pkg::ST_IDLE
                                                            : ffd_pkg::ST_INIT_VWAIT;
         ffd_pkg::ST_INIT_VWAIT: if (div_done) state_in = ffd_pkg::ST_IDLE;
         ffd_pkg::ST_IDLE:       if (accept) state_in = ffd_pkg::ST_CHK_D1;
         ffd_pkg::ST_CHK_D1:     state_in = ffd_pkg::ST_CHK_D2;
         ffd_pkg::ST_CHK_D2:     state_in = ffd_pkg::ST_CHK_U1;
         ffd_pkg::ST_CHK_U1:     state_in = ffd_pkg::ST_CHK_U2;
         ffd_pkg::ST_CHK_U2:     state_in = ffd_pkg::ST_DECIDE;
         ffd_pkg::ST_DECIDE:     state_in = ffd_pkg::ST_CLEAN_DIV;
         ffd_pkg::ST_CLEAN_DIV:  state_in = ffd_pkg::ST_CLEAN_WAIT;
         ffd_pkg::ST_CLEAN_WAIT: if (div_done) state_in = ffd_pkg::ST_VEL_DIV;
         ffd_pkg::ST_VEL_DIV:    state_in = (cur_ff == '0) ? ffd_pkg::ST_ACC_MUL
                                                            : ffd_pkg::ST_VEL_WAIT;
         ffd_pkg::ST_VEL_WAIT:   if (div_done) state_in = ffd_pkg::ST_ACC_MUL;
         ffd_pkg::ST_ACC_MUL:    state_in = ffd_pkg::ST_ACC_DIV;
         ffd_pkg::ST_ACC_DIV:    state_in = (cur_ff == '0) ? ffd_pkg::ST_WALK
                                                            : ffd_pkg::ST_ACC_WAIT;
         ffd_pkg::ST_ACC_WAIT:   if (div_done) state_in = ffd_pkg::ST_WALK;
         ffd_pkg::ST_WALK:       if (idx_ff == '0) state_in = ffd_pkg::ST_DONE;
         ffd_pkg::ST_DONE:       if (out_free) state_in = ffd_pkg::ST_IDLE;
         default:                state_in = ffd_pkg::ST_INIT;
      endcase
      if (csr_we) begin
         state_in = ffd_pkg::ST_INIT;
      end
   end

   // unit control
   always_comb begin
      mul_en      = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_req     = '0;
      req_tready  = (state_ff == ffd_pkg::ST_IDLE);
      unique case (state_ff)
         ffd_pkg::ST_INIT: begin
            mul_en = 1'b1;
            mul_a  = MA_W'(max_ff);
            mul_b  = MB_W'(n);
         end
         ffd_pkg::ST_INIT_SUM, ffd_pkg::ST_DECIDE: begin
            mul_en = 1'b1;
            mul_a  = MA_W'(angle_ff);
            mul_b  = ffd_pkg::US_PER_S;
         end
         ffd_pkg::ST_INIT_VDIV: begin
            div_req.start = (max_ff != '0);
            div_req.num   = mul_ff[NUM_W-1:0] + NUM_W'({max_ff, 3'b000});
            div_req.den   = DEN_W'({max_ff, 4'b0000});
         end
         ffd_pkg::ST_CHK_D1: begin
            mul_en = 1'b1;
            mul_a  = MA_W'(prev_ff);
            mul_b  = MB_W'(down_ff);
         end
         ffd_pkg::ST_CHK_U1: begin
            mul_en = 1'b1;
            mul_a  = MA_W'(prev_ff);
            mul_b  = MB_W'(up_ff);
         end
         ffd_pkg::ST_CHK_D2, ffd_pkg::ST_CHK_U2: begin
            mul_en = 1'b1;
            mul_a  = mul_ff[MA_W-1:0];
            mul_b  = MB_W'(n);
         end
         ffd_pkg::ST_CLEAN_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(sum_ff) + NUM_W'(n >> 1);
            div_req.den   = DEN_W'(n);
         end
         ffd_pkg::ST_VEL_DIV: begin
            div_req.start = (cur_ff != '0);
            div_req.num   = mul_ff[NUM_W-1:0] + NUM_W'({cur_ff, 3'b000});
            div_req.den   = DEN_W'({cur_ff, 4'b0000});
         end
         ffd_pkg::ST_ACC_MUL: begin
            mul_en = 1'b1;
            mul_a  = MA_W'(mag);
            mul_b  = ffd_pkg::US_PER_S;
         end
         ffd_pkg::ST_ACC_DIV: begin
            div_req.start = (cur_ff != '0);
            div_req.num   = mul_ff[NUM_W-1:0] + NUM_W'({cur_ff, 7'd0});
            div_req.den   = DEN_W'({cur_ff, 8'd0});
         end
         default: begin
         end
      endcase
   end

   ffd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffd_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
         min_ff       <= ffd_pkg::RST_MIN_INTERVAL;
         max_ff       <= ffd_pkg::RST_MAX_INTERVAL;
         down_ff      <= ffd_pkg::RST_DOWN_RATIO;
         up_ff        <= ffd_pkg::RST_UP_RATIO;
         flank_ff     <= ffd_pkg::RST_FLANK_LENGTH;
         window_ff    <= ffd_pkg::RST_WINDOW;
         errors_ff    <= ffd_pkg::RST_ERRORS;
         angle_ff     <= ffd_pkg::RST_ANGLE;
         corr_cnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ffd_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (ffd_pkg::csr_index_type'(csr_index))
               ffd_pkg::CSR_MIN_INTERVAL: min_ff    <= csr_wdata;
               ffd_pkg::CSR_MAX_INTERVAL: max_ff    <= csr_wdata;
               ffd_pkg::CSR_DOWN_RATIO:   down_ff   <= csr_wdata[15:0];
               ffd_pkg::CSR_UP_RATIO:     up_ff     <= csr_wdata[15:0];
               ffd_pkg::CSR_FLANK_LENGTH: flank_ff  <= csr_wdata[3:0];
               ffd_pkg::CSR_WINDOW:       window_ff <= csr_wdata[3:0];
               ffd_pkg::CSR_ERRORS:       errors_ff <= csr_wdata[3:0];
               ffd_pkg::CSR_ANGLE:        angle_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         unique case (state_ff)
            ffd_pkg::ST_INIT: corr_cnt_ff <= '0;
            ffd_pkg::ST_DECIDE: begin
               if (pass) begin
                  corr_cnt_ff <= '0;
               end else if (corr_cnt_ff <= limit) begin
                  corr_cnt_ff <= corr_cnt_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (mul_en) begin
         mul_ff <= MUL_W'(mul_a) * MUL_W'(mul_b);
      end

      unique case (state_ff)
         ffd_pkg::ST_INIT: begin
            for (int i = 0; i < FLANK_DEPTH; i++) begin
               raw_ff[i]   <= max_ff;
               clean_ff[i] <= max_ff;
               acc_ff[i]   <= ffd_pkg::ACC_INIT;
            end
            for (int i = 0; i < MAX_WINDOW; i++) begin
               win_ff[i] <= max_ff;
            end
         end
         ffd_pkg::ST_INIT_SUM: sum_ff <= mul_ff[SUM_W-1:0];
         ffd_pkg::ST_INIT_VDIV: begin
            if (max_ff == '0) begin
               for (int i = 0; i < FLANK_DEPTH; i++) begin
                  vel_ff[i] <= '0;
               end
            end
         end
         ffd_pkg::ST_INIT_VWAIT: begin
            if (div_done) begin
               for (int i = 0; i < FLANK_DEPTH; i++) begin
                  vel_ff[i] <= v_sat;
               end
            end
         end
         ffd_pkg::ST_IDLE: begin
            if (accept) begin
               // only entries up to the flank length move
               for (int i = 1; i < FLANK_DEPTH; i++) begin
                  if (IDX_W'(i) <= len) begin
                     raw_ff[i]   <= raw_ff[i-1];
                     clean_ff[i] <= clean_ff[i-1];
                     vel_ff[i]   <= vel_ff[i-1];
                     acc_ff[i]   <= acc_ff[i-1];
                  end
               end
               raw_ff[0] <= x;
               for (int i = 1; i < MAX_WINDOW; i++) begin
                  win_ff[i] <= win_ff[i-1];
               end
               win_ff[0] <= data;
               sum_ff    <= sum_ff - SUM_W'(win_ff[WIX_W'(n - 1'b1)]) + SUM_W'(data);
               prev_ff   <= prev;
               data_ff   <= data;
               oob_ff    <= oob;
               corr_ff   <= 1'b0;
               idx_ff    <= len;
               ft_ff     <= '0;
               perr_ff   <= '0;
               uerr_ff   <= '0;
            end
         end
         ffd_pkg::ST_CHK_U1: lo_ff <= mul_ff;
         ffd_pkg::ST_DECIDE: begin
            if (!pass && corr_cnt_ff <= limit) begin
               win_ff[0] <= prev_ff;
               corr_ff   <= 1'b1;
               sum_ff    <= sum_ff - SUM_W'(data_ff) + SUM_W'(prev_ff);
            end
         end
         ffd_pkg::ST_CLEAN_WAIT: begin
            if (div_done) begin
               cur_ff      <= div_quo[IW-1:0];
               clean_ff[0] <= div_quo[IW-1:0];
            end
         end
         ffd_pkg::ST_VEL_DIV: begin
            if (cur_ff == '0) begin
               vel_ff[0] <= '0;
            end
         end
         ffd_pkg::ST_VEL_WAIT: begin
            if (div_done) begin
               vel_ff[0] <= v_sat;
            end
         end
         ffd_pkg::ST_ACC_MUL: neg_ff <= (vel_ff[0] < vel_ff[1]);
         ffd_pkg::ST_ACC_DIV: begin
            if (cur_ff == '0) begin
               acc_ff[0] <= '0;
            end
         end
         ffd_pkg::ST_ACC_WAIT: begin
            if (div_done) begin
               acc_ff[0] <= neg_ff ? -a_mag : a_mag;
            end
         end
         ffd_pkg::ST_WALK: begin
            ft_ff <= ft_ff + FTA_W'(raw_ff[idx_ff]);
            if (idx_ff != '0) begin
               // nearest pair counts equality as an error for the powered test
               if ((idx_ff == IDX_W'(1)) ? (walk_a <= walk_b) : (walk_a < walk_b)) begin
                  perr_ff <= perr_ff + 1'b1;
               end
               if (walk_a >= walk_b) begin
                  uerr_ff <= uerr_ff + 1'b1;
               end
               idx_ff <= idx_ff - 1'b1;
            end else if (len == '0 && clean_ff[1] <= clean_ff[0]) begin
               // zero flank length: powered test still looks at the newest pair
               perr_ff <= perr_ff + 1'b1;
            end
         end
         ffd_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_data_ff <= {4'b0000, acc_ff[ai], clean_ff[bi],
                               ft_ff[FTA_W-1] ? {ffd_pkg::FT_W{1'b1}}
                                              : ft_ff[ffd_pkg::FT_W-1:0],
                               acc_ff[0], vel_ff[0], cur_ff};
               rsp_user_ff <= {corr_ff, oob_ff, uerr_ff <= errors_ff, perr_ff <= errors_ff};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== tb/tb_flywheel_flank_detector_top.sv =====
typedef struct {
   logic [23:0] clean_interval;
   logic [31:0] velocity;
   logic [47:0] acceleration;
   logic        powered;
   logic        unpowered;
   logic [27:0] flank_time;
   logic [23:0] begin_interval;
   logic [47:0] begin_acceleration;
   logic        out_of_bounds;
   logic        corrected;
} flank_result_type;

class flank_scoreboard;
   localparam int DEPTH = 16;
   localparam int WIN   = 8;

   logic [23:0] min_iv, max_iv, angle;
   logic [15:0] down_r, up_r;
   logic [3:0]  flank_len, window, errs_ok;

   logic [23:0] raw_hist[DEPTH];
   logic [23:0] clean_hist[DEPTH];
   logic [31:0] vel_hist[DEPTH];
   logic [47:0] acc_hist[DEPTH];
   logic [23:0] avg_win[WIN];
   int unsigned fix_count;

   flank_result_type pending[$];
   int errors;

   function new();
      errors = 0;
      min_iv = ffd_pkg::RST_MIN_INTERVAL; max_iv = ffd_pkg::RST_MAX_INTERVAL;
      down_r = ffd_pkg::RST_DOWN_RATIO; up_r = ffd_pkg::RST_UP_RATIO;
      flank_len = ffd_pkg::RST_FLANK_LENGTH; window = ffd_pkg::RST_WINDOW;
      errs_ok = ffd_pkg::RST_ERRORS; angle = ffd_pkg::RST_ANGLE;
      reload();
   endfunction

   function logic [31:0] vel_of(logic [23:0] c);
      logic [63:0] num, den, q;
      if (c == 0) return 0;
      num = 64'(angle) * 64'd1000000;
      den = 64'(c) * 16;
      q = (num + den / 2) / den;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function logic [47:0] acc_of(logic [31:0] v0, logic [31:0] v1, logic [23:0] c);
      logic [63:0] mag, den, q;
      if (c == 0) return 0;
      mag = (v0 < v1) ? 64'(v1 - v0) : 64'(v0 - v1);
      den = 64'(c) * 256;
      q = (mag * 64'd1000000 + den / 2) / den;
      if (q > 64'(ffd_pkg::ACC_MAX)) q = 64'(ffd_pkg::ACC_MAX);
      return (v0 < v1) ? -q[47:0] : q[47:0];
   endfunction

   function void reload();
      logic [31:0] v;
      v = vel_of(max_iv);
      for (int i = 0; i < DEPTH; i++) begin
         raw_hist[i] = max_iv; clean_hist[i] = max_iv;
         vel_hist[i] = v; acc_hist[i] = ffd_pkg::ACC_INIT;
      end
      for (int i = 0; i < WIN; i++) avg_win[i] = max_iv;
      fix_count = 0;
   endfunction

   function void write_reg(ffd_pkg::csr_index_type idx, logic [23:0] d);
      case (idx)
         ffd_pkg::CSR_MIN_INTERVAL: min_iv = d;
         ffd_pkg::CSR_MAX_INTERVAL: max_iv = d;
         ffd_pkg::CSR_DOWN_RATIO:   down_r = d[15:0];
         ffd_pkg::CSR_UP_RATIO:     up_r = d[15:0];
         ffd_pkg::CSR_FLANK_LENGTH: flank_len = d[3:0];
         ffd_pkg::CSR_WINDOW:       window = d[3:0];
         ffd_pkg::CSR_ERRORS:       errs_ok = d[3:0];
         ffd_pkg::CSR_ANGLE:        angle = d;
      endcase
      reload();
   endfunction

   function void note_interval(logic [23:0] x);
      flank_result_type r;
      int unsigned len, n, lim, e, ai;
      logic [63:0] sum, ft;
      logic [23:0] prev, data, c;
      len = (flank_len < DEPTH - 1) ? flank_len : DEPTH - 1;
      n = (window == 0) ? 1 : (window > WIN) ? WIN : window;
      lim = (n < 2) ? 2 : n;
      for (int i = len; i > 0; i--) begin
         raw_hist[i] = raw_hist[i-1]; clean_hist[i] = clean_hist[i-1];
         vel_hist[i] = vel_hist[i-1]; acc_hist[i] = acc_hist[i-1];
      end
      raw_hist[0] = x;
      prev = clean_hist[1];
      r.out_of_bounds = (x < min_iv) || (x > max_iv);
      data = r.out_of_bounds ? prev : x;
      for (int i = WIN - 1; i > 0; i--) avg_win[i] = avg_win[i-1];
      avg_win[0] = data;
      sum = 0;
      for (int i = 0; i < n; i++) sum += avg_win[i];
      r.corrected = 0;
      if (sum * 256 > 64'(down_r) * prev * n && sum * 256 < 64'(up_r) * prev * n)
         fix_count = 0;
      else if (fix_count <= lim) begin
         avg_win[0] = prev;
         fix_count++;
         r.corrected = 1;
         sum = 0;
         for (int i = 0; i < n; i++) sum += avg_win[i];
      end
      c = 24'((sum + n / 2) / n);
      clean_hist[0] = c;
      vel_hist[0] = vel_of(c);
      acc_hist[0] = acc_of(vel_hist[0], vel_hist[1], c);
      e = 0;
      for (int i = len; i > 1; i--) if (clean_hist[i] < clean_hist[i-1]) e++;
      if (clean_hist[1] <= clean_hist[0]) e++;
      r.powered = (e <= errs_ok);
      e = 0;
      for (int i = len; i > 0; i--) if (clean_hist[i] >= clean_hist[i-1]) e++;
      r.unpowered = (e <= errs_ok);
      ft = 0;
      for (int i = 0; i <= len; i++) ft += raw_hist[i];
      if (ft > 64'hFFF_FFFF) ft = 64'hFFF_FFFF;
      ai = (flank_len == 0) ? 0 : flank_len - 1;
      r.clean_interval = c;
      r.velocity = vel_hist[0];
      r.acceleration = acc_hist[0];
      r.flank_time = ft[27:0];
      r.begin_interval = clean_hist[len];
      r.begin_acceleration = acc_hist[ai];
      pending.push_back(r);
   endfunction

   function void check_result(logic [207:0] d, logic [3:0] u);
      flank_result_type e;
      if (pending.size() == 0) begin
         $error("result beat with nothing expected");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (d[23:0] != e.clean_interval) begin
         $error("clean_interval exp %0d got %0d", e.clean_interval, d[23:0]); errors++;
      end
      if (d[55:24] != e.velocity) begin
         $error("velocity exp %0d got %0d", e.velocity, d[55:24]); errors++;
      end
      if (d[103:56] != e.acceleration) begin
         $error("acceleration exp %h got %h", e.acceleration, d[103:56]); errors++;
      end
      if (d[131:104] != e.flank_time) begin
         $error("flank_time exp %0d got %0d", e.flank_time, d[131:104]); errors++;
      end
      if (d[155:132] != e.begin_interval) begin
         $error("begin_interval exp %0d got %0d", e.begin_interval, d[155:132]); errors++;
      end
      if (d[203:156] != e.begin_acceleration) begin
         $error("begin_acceleration exp %h got %h", e.begin_acceleration, d[203:156]);
         errors++;
      end
      if (u[0] != e.powered) begin
         $error("powered exp %0d got %0d", e.powered, u[0]); errors++;
      end
      if (u[1] != e.unpowered) begin
         $error("unpowered exp %0d got %0d", e.unpowered, u[1]); errors++;
      end
      if (u[2] != e.out_of_bounds) begin
         $error("out_of_bounds exp %0d got %0d", e.out_of_bounds, u[2]); errors++;
      end
      if (u[3] != e.corrected) begin
         $error("corrected exp %0d got %0d", e.corrected, u[3]); errors++;
      end
   endfunction
endclass

module tb_flywheel_flank_detector_top;
   localparam int CYCLE_LIMIT = 2000000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [23:0]   req_tdata = 0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [207:0]  rsp_tdata;
   logic [3:0]    rsp_tuser;
   logic          csr_we = 0;
   logic [2:0]    csr_index = 0;
   logic [23:0]   csr_wdata = 0;

   flank_scoreboard flank_sb;
   int  cycle_count = 0;
   int  hold_off = 0;     // cycles the receiver stays stalled
   bit  calm = 0;         // no idling on either side

   flywheel_flank_detector_top u_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stalls, optional long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) flank_sb.check_result(rsp_tdata, rsp_tuser);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else
         rsp_tready <= calm || ($urandom_range(99) >= 18);
   end

   // valid stays up after a beat so the next one can follow at once
   task automatic send_interval(logic [23:0] x);
      if (!calm) begin
         while ($urandom_range(99) < 18) begin
            req_tvalid <= 0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1;
      req_tdata <= x;
      do @(posedge clock); while (!req_tready);
      flank_sb.note_interval(x);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (flank_sb.pending.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task automatic write_csr(ffd_pkg::csr_index_type idx, logic [23:0] d);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      flank_sb.write_reg(idx, d);
      csr_we <= 0;
      @(posedge clock);
   endtask

   // a steady spin-up or spin-down with jitter and occasional glitches
   task automatic send_run(int count);
      logic [23:0] base;
      int step;
      base = $urandom_range(flank_sb.max_iv > 0 ? flank_sb.max_iv : 1, 1);
      step = $urandom_range(200) - 100;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0)
            send_interval(($urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(3)));
         else
            send_interval(24'(int'(base) + int'(base) * step * i / 2000
                               + $urandom_range(64) - 32));
      end
   endtask

   task automatic random_config(bit extreme);
      write_csr(ffd_pkg::CSR_MIN_INTERVAL, extreme ? 24'($urandom_range(1)) * 24'hFFFFFF
                                                   : 24'($urandom_range(20000)));
      write_csr(ffd_pkg::CSR_MAX_INTERVAL, extreme ? (($urandom_range(1)) ? 24'hFFFFFF : 24'd1)
                                                   : 24'($urandom_range(3000000, 30000)));
      write_csr(ffd_pkg::CSR_DOWN_RATIO, extreme ? 16'($urandom_range(1) * 65535)
                                                 : 16'($urandom_range(250, 100)));
      write_csr(ffd_pkg::CSR_UP_RATIO, extreme ? 16'($urandom_range(1) * 65535)
                                               : 16'($urandom_range(600, 260)));
      write_csr(ffd_pkg::CSR_FLANK_LENGTH, extreme ? 24'($urandom_range(1) ? 15 : 1)
                                                   : 24'($urandom_range(15)));
      write_csr(ffd_pkg::CSR_WINDOW, extreme ? 24'($urandom_range(1) ? 15 : 0)
                                             : 24'($urandom_range(8, 1)));
      write_csr(ffd_pkg::CSR_ERRORS, 24'($urandom_range(15)));
      write_csr(ffd_pkg::CSR_ANGLE, extreme ? 24'($urandom_range(1) ? 24'hFFFFFF : 1)
                                            : 24'($urandom));
   endtask

   initial begin
      flank_sb = new();
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: extremes, bounds, limiter and zero cases at reset settings
      send_interval(24'd0);
      send_interval(24'hFFFFFF);
      send_interval(24'd10000);
      send_interval(24'd1000000);
      send_interval(24'd9999);
      send_interval(24'd1000001);
      send_interval(24'd500000);
      send_interval(24'd400000);
      send_interval(24'd300000);
      send_interval(24'd350000);
      send_interval(24'd450000);
      send_interval(24'h555555);
      send_interval(24'hAAAAAA);
      drain();
      // min above max, zero max, longest flank, widest window
      write_csr(ffd_pkg::CSR_MIN_INTERVAL, 24'hFFFFFF);
      write_csr(ffd_pkg::CSR_MAX_INTERVAL, 24'd0);
      write_csr(ffd_pkg::CSR_FLANK_LENGTH, 24'd15);
      write_csr(ffd_pkg::CSR_WINDOW, 24'd15);
      write_csr(ffd_pkg::CSR_ERRORS, 24'd15);
      write_csr(ffd_pkg::CSR_ANGLE, 24'hFFFFFF);
      write_csr(ffd_pkg::CSR_DOWN_RATIO, 24'hFFFF);
      write_csr(ffd_pkg::CSR_UP_RATIO, 24'd0);
      send_interval(24'd0);
      send_interval(24'd5);
      send_interval(24'hFFFFFF);
      drain();
      write_csr(ffd_pkg::CSR_MIN_INTERVAL, 24'd0);
      write_csr(ffd_pkg::CSR_MAX_INTERVAL, 24'hFFFFFF);
      write_csr(ffd_pkg::CSR_WINDOW, 24'd0);
      write_csr(ffd_pkg::CSR_FLANK_LENGTH, 24'd0);
      send_interval(24'd1);
      send_interval(24'hFFFFFF);
      send_interval(24'd2);
      drain();

      // long receiver hold-off with the sender pushing on
      hold_off <= 400;
      calm = 0;
      for (int i = 0; i < 8; i++) send_interval(24'($urandom));
      drain();

      for (int phase = 0; phase < 32; phase++) begin
         random_config(phase % 5 == 0);
         calm = (phase == 7);
         for (int k = 0; k < 5; k++) send_run($urandom_range(12, 6));
         for (int k = 0; k < 3; k++) send_interval(24'($urandom));
         drain();
      end
      calm = 0;

      if (flank_sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/ffd_pkg.sv
rtl/ffd_div.sv
rtl/flywheel_flank_detector_top.sv
tb/tb_flywheel_flank_detector_top.sv
